// File: hw/rtl/vgm_pkg.sv
package vgm_pkg;

    localparam int ADDR_BITS     = 16;
    localparam int MAX_CMDS      = 64;

    localparam int STORE_DEPTH   = 1 << ADDR_BITS;
    localparam int CNT_W         = $clog2(MAX_CMDS + 1);
    localparam int BUF_AW        = (MAX_CMDS > 1) ? $clog2(MAX_CMDS) : 1;
    localparam int BUF_DEPTH     = 1 << BUF_AW;

    localparam int WAIT_W        = 16;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 40;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 1'd1;

    localparam logic [7:0] OP_WRITE      = 8'hB4;
    localparam logic [7:0] OP_WAIT_SHORT = 8'h70;
    localparam logic [7:0] OP_NIBBLE_LO  = 8'h0F;
    localparam logic [7:0] OP_NIBBLE_HI  = 8'hF0;
    localparam logic [7:0] OP_WAIT_LONG  = 8'h61;
    localparam logic [7:0] OP_WAIT_FRAME = 8'h62;
    localparam logic [7:0] OP_LOOP       = 8'h66;

    localparam logic [WAIT_W-1:0] FRAME_WAIT = 16'd735;

    typedef enum logic [2:0] {
        KIND_WRITE,
        KIND_WAIT_SHORT,
        KIND_WAIT_LONG,
        KIND_WAIT_FRAME,
        KIND_LOOP,
        KIND_SKIP
    } cmd_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CMD,
        ST_DECODE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RD_LO,
        ST_RD_HI,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic begin_item;
        logic store_wr;
        logic dec_wait;
        logic fetch;
        logic count_cmd;
        logic set_overrun;
        logic latch_addr;
        logic latch_lo;
        logic push_write;
        logic set_wait_short;
        logic set_wait_long;
        logic set_wait_frame;
        logic jump_loop;
        logic buf_rd;
        logic out_load_write;
        logic out_load_status;
    } ctrl_t;

    typedef struct packed {
        logic      action;
        logic      play_enable;
        logic      wait_zero;
        logic      cap_hit;
        cmd_kind_t kind;
        logic      long_zero;
        logic      nwr_zero;
        logic      emit_last;
        logic      out_free;
    } stat_t;

    function automatic cmd_kind_t decode_cmd(input logic [7:0] b);
        cmd_kind_t k;
        if (b == OP_WRITE)
            k = KIND_WRITE;
        else if ((b & OP_NIBBLE_HI) == OP_WAIT_SHORT)
            k = KIND_WAIT_SHORT;
        else if (b == OP_WAIT_LONG)
            k = KIND_WAIT_LONG;
        else if (b == OP_WAIT_FRAME)
            k = KIND_WAIT_FRAME;
        else if (b == OP_LOOP)
            k = KIND_LOOP;
        else
            k = KIND_SKIP;
        return k;
    endfunction

endpackage

// File: hw/rtl/vgm_ctrl.sv
module vgm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  vgm_pkg::stat_t stat,
    output vgm_pkg::ctrl_t cmd
);
    import vgm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (stat.action && stat.play_enable && stat.wait_zero)
                        state_next = ST_RD_CMD;
                    else
                        state_next = ST_STATUS;
                end
            end
            ST_RD_CMD:
                state_next = stat.cap_hit ? ST_DRAIN : ST_DECODE;
            ST_DECODE:
            begin
                case (stat.kind)
                    KIND_WRITE:      state_next = ST_RD_ADDR;
                    KIND_WAIT_SHORT: state_next = ST_DRAIN;
                    KIND_WAIT_LONG:  state_next = ST_RD_LO;
                    KIND_WAIT_FRAME: state_next = ST_DRAIN;
                    default:         state_next = ST_RD_CMD;
                endcase
            end
            ST_RD_ADDR:  state_next = ST_RD_DATA;
            ST_RD_DATA:  state_next = ST_RD_CMD;
            ST_RD_LO:    state_next = ST_RD_HI;
            ST_RD_HI:    state_next = stat.long_zero ? ST_RD_CMD : ST_DRAIN;
            ST_DRAIN:    state_next = stat.nwr_zero ? ST_STATUS : ST_EMIT_RD;
            ST_EMIT_RD:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (stat.out_free)
                    state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.begin_item = 1'b1;
                    if (!stat.action)
                        cmd.store_wr = 1'b1;
                    else if (stat.play_enable && !stat.wait_zero)
                        cmd.dec_wait = 1'b1;
                end
            end
            ST_RD_CMD:
            begin
                if (stat.cap_hit)
                    cmd.set_overrun = 1'b1;
                else
                begin
                    cmd.count_cmd = 1'b1;
                    cmd.fetch     = 1'b1;
                end
            end
            ST_DECODE:
            begin
                case (stat.kind)
                    KIND_WRITE:      cmd.fetch          = 1'b1;
                    KIND_WAIT_SHORT: cmd.set_wait_short = 1'b1;
                    KIND_WAIT_LONG:  cmd.fetch          = 1'b1;
                    KIND_WAIT_FRAME: cmd.set_wait_frame = 1'b1;
                    KIND_LOOP:       cmd.jump_loop      = 1'b1;
                    default:         ;
                endcase
            end
            ST_RD_ADDR:
            begin
                cmd.latch_addr = 1'b1;
                cmd.fetch      = 1'b1;
            end
            ST_RD_DATA:  cmd.push_write = 1'b1;
            ST_RD_LO:
            begin
                cmd.latch_lo = 1'b1;
                cmd.fetch    = 1'b1;
            end
            ST_RD_HI:    cmd.set_wait_long = 1'b1;
            ST_EMIT_RD:  cmd.buf_rd = 1'b1;
            ST_EMIT_OUT: cmd.out_load_write = stat.out_free;
            ST_STATUS:   cmd.out_load_status = stat.out_free;
            default:     ;
        endcase
    end

endmodule

// File: hw/rtl/vgm_datapath.sv
module vgm_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vgm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vgm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tuser,
    input  logic [vgm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    output logic [vgm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  vgm_pkg::ctrl_t                     cmd,
    output vgm_pkg::stat_t                     stat
);
    import vgm_pkg::*;

    logic [7:0]           store_mem [STORE_DEPTH];
    logic [15:0]          wbuf_mem  [BUF_DEPTH];

    logic                 play_enable_reg;
    logic [ADDR_BITS-1:0] loop_start_reg;
    logic [ADDR_BITS-1:0] pos_reg;
    logic [WAIT_W-1:0]    wait_reg;
    logic [CNT_W-1:0]     cmds_reg;
    logic [CNT_W-1:0]     nwr_reg;
    logic [CNT_W-1:0]     emit_k_reg;
    logic                 overrun_reg;
    logic [7:0]           rdata_reg;
    logic [7:0]           addr_byte_reg;
    logic [7:0]           lo_byte_reg;
    logic [15:0]          buf_rdata_reg;

    logic                 out_valid_reg;
    logic                 out_wv_reg;
    logic                 out_last_reg;
    logic                 out_ovr_reg;
    logic [7:0]           out_areg_reg;
    logic [7:0]           out_data_reg;
    logic [WAIT_W-1:0]    out_wait_reg;

    logic [ADDR_BITS-1:0] load_addr;
    logic [7:0]           load_byte;
    logic                 out_free;
    logic                 emit_last;

    assign load_addr = ADDR_BITS'(s_axis_tdata[15:0]);
    assign load_byte = s_axis_tdata[23:16];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit_last = (emit_k_reg + CNT_W'(1)) == nwr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
            store_mem[load_addr] <= load_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
            rdata_reg <= store_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_write)
            wbuf_mem[nwr_reg[BUF_AW-1:0]] <= {rdata_reg, addr_byte_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.buf_rd)
            buf_rdata_reg <= wbuf_mem[emit_k_reg[BUF_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_addr)
            addr_byte_reg <= rdata_reg;
        if (cmd.latch_lo)
            lo_byte_reg <= rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_enable_reg <= 1'b0;
            loop_start_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PLAY_ENABLE: play_enable_reg <= cfg_data[0];
                CFG_LOOP_START:  loop_start_reg  <= ADDR_BITS'(cfg_data);
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wait_reg    <= '0;
            cmds_reg    <= '0;
            nwr_reg     <= '0;
            emit_k_reg  <= '0;
            overrun_reg <= 1'b0;
        end
        else
        begin
            if (cmd.begin_item)
            begin
                cmds_reg    <= '0;
                nwr_reg     <= '0;
                emit_k_reg  <= '0;
                overrun_reg <= 1'b0;
            end
            if (cmd.dec_wait)
                wait_reg <= wait_reg - WAIT_W'(1);
            if (cmd.set_wait_short)
                wait_reg <= WAIT_W'(rdata_reg & OP_NIBBLE_LO) + WAIT_W'(1);
            if (cmd.set_wait_long)
                wait_reg <= {rdata_reg, lo_byte_reg};
            if (cmd.set_wait_frame)
                wait_reg <= FRAME_WAIT;
            // Every byte read advances the position, wrapping at the end of the store.
            if (cmd.fetch)
                pos_reg <= pos_reg + ADDR_BITS'(1);
            else if (cmd.jump_loop)
                pos_reg <= loop_start_reg;
            if (cmd.count_cmd)
                cmds_reg <= cmds_reg + CNT_W'(1);
            if (cmd.set_overrun)
                overrun_reg <= 1'b1;
            if (cmd.push_write)
                nwr_reg <= nwr_reg + CNT_W'(1);
            if (cmd.out_load_write)
                emit_k_reg <= emit_k_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load_write || cmd.out_load_status)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Results leave only after the tick has finished, so the final wait and
    // overrun are known for every buffered register write.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_write)
        begin
            out_wv_reg   <= 1'b1;
            out_areg_reg <= buf_rdata_reg[7:0];
            out_data_reg <= buf_rdata_reg[15:8];
            out_wait_reg <= wait_reg;
            out_ovr_reg  <= overrun_reg;
            out_last_reg <= emit_last;
        end
        else if (cmd.out_load_status)
        begin
            out_wv_reg   <= 1'b0;
            out_areg_reg <= '0;
            out_data_reg <= '0;
            out_wait_reg <= wait_reg;
            out_ovr_reg  <= overrun_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_wv_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_ovr_reg, out_wait_reg, out_data_reg, out_areg_reg};

    always_comb
    begin
        stat.action      = s_axis_tuser;
        stat.play_enable = play_enable_reg;
        stat.wait_zero   = (wait_reg == '0);
        stat.cap_hit     = (cmds_reg == CNT_W'(MAX_CMDS));
        stat.kind        = decode_cmd(rdata_reg);
        stat.long_zero   = ({rdata_reg, lo_byte_reg} == 16'd0);
        stat.nwr_zero    = (nwr_reg == '0);
        stat.emit_last   = emit_last;
        stat.out_free    = out_free;
    end

endmodule

// File: hw/rtl/vgm_apu_command_player.sv
// A load transaction or an idle tick presents its one result once the output register is free.
// A running tick reads each command, and the operand bytes of 0xB4 and 0x61 commands, through
// the registered read of the single-port command store, then emits each buffered register write;
// reading stops at the 64-command cap. The next input is accepted once the last result sits in
// the output register, so no new input is taken before the last one is finished. Reset clears
// state, configuration, position, wait, counters and output valid only, not the stores.
module vgm_apu_command_player (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vgm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vgm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic                               s_axis_tuser,  // action
    input  logic [vgm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // load_address, load_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic                               m_axis_tuser,  // write_valid
    output logic                               m_axis_tlast,
    // apu_register, apu_data, wait_left, overrun, zero padding
    output logic [vgm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import vgm_pkg::*;

    ctrl_t cmd;
    stat_t stat;

    vgm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    vgm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

    // A result without a register write is always the only result of its input.
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("status result without last");

    // Every accepted input keeps the block busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // The store is written only by an accepted load transaction.
    a_store_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> s_axis_tvalid && s_axis_tready && !s_axis_tuser)
        else $error("store write without load transaction");

    // Buffered results never leave while the command stream is still being read.
    a_no_emit_while_fetching: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> !cmd.out_load_write && !cmd.out_load_status)
        else $error("result loaded during command fetch");

endmodule
